// File: rtl/c3c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3c_pkg
// Shared constants and types for the three-C miss classifier.
// ----------------------------------------------------------------------------
package c3c_pkg;

  localparam int CNT_W = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration register indexes.
  localparam logic [1:0] REG_LINE_SHIFT = 2'd0;
  localparam logic [1:0] REG_SET_BITS   = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;
  localparam logic [1:0] REG_FA_LINES   = 2'd3;

  // Miss kinds.
  localparam logic [1:0] KIND_COMPULSORY = 2'd0;
  localparam logic [1:0] KIND_CAPACITY   = 2'd1;
  localparam logic [1:0] KIND_CONFLICT   = 2'd2;

  // Status returned by a shadow cache engine.
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } lru_stat_t;

endpackage

// File: rtl/c3c_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3c_lru
// Sequential LRU shadow cache: one tag/rank memory swept entry by entry.
// ----------------------------------------------------------------------------
module c3c_lru #(
  parameter int ENTRIES = 512,
  parameter int SPAN    = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  clear,
  input  logic                                  start,
  input  logic [31:0]                           line,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] base,
  input  logic [$clog2(SPAN+1)-1:0]             n,
  output c3c_pkg::lru_stat_t                    stat
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(SPAN + 1);
  localparam int RW = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int DW = 33 + RW;

  typedef enum logic [4:0] {
    L_CLR  = 5'b00001,
    L_IDLE = 5'b00010,
    L_FIND = 5'b00100,
    L_AGE  = 5'b01000,
    L_FILL = 5'b10000
  } lstate_t;

  lstate_t state;
  logic [NW-1:0] idx;
  logic pv;
  logic [IW-1:0] addr_q;
  logic [DW-1:0] rdata;
  // Each word holds a valid bit, the tag and the recency rank.
  logic [DW-1:0] mem [ENTRIES];
  logic [IW-1:0] clr_addr;
  logic [NW-1:0] cnt;
  logic hit_f, got_free, done_q;
  logic [IW-1:0] free_idx, hit_idx, max_idx, vic;
  logic [RW-1:0] r_hit, max_r, age_r;

  logic scanning, rd_en, end_scan, vq, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic [31:0] tag_q;
  logic [RW-1:0] rank_q;

  assign scanning = (state == L_FIND) || (state == L_AGE);
  assign rd_en    = scanning && (idx < n);
  assign rd_addr  = base + IW'(idx);
  assign end_scan = (idx == n) && !pv;
  assign vq       = rdata[DW-1];
  assign tag_q    = rdata[DW-2:RW];
  assign rank_q   = rdata[RW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = {1'b1, tag_q, rank_q + RW'(1)};
    if (state == L_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == L_AGE && pv && vq && (rank_q < age_r)) begin
      wr_en = 1'b1;
    end else if (state == L_FILL) begin
      wr_en   = 1'b1;
      wr_addr = vic;
      wr_data = {1'b1, line, {RW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      // Every word is zeroed in turn before the next lookup.
      state    <= L_CLR;
      clr_addr <= '0;
      pv       <= 1'b0;
      done_q   <= 1'b0;
      idx      <= '0;
    end else begin
      pv     <= rd_en;
      done_q <= 1'b0;
      if (rd_en) begin
        idx <= idx + NW'(1);
      end
      unique case (state)
        L_CLR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(ENTRIES - 1)) begin
            state <= L_IDLE;
          end
        end
        L_IDLE: begin
          if (start) begin
            idx      <= '0;
            cnt      <= '0;
            hit_f    <= 1'b0;
            got_free <= 1'b0;
            max_r    <= '0;
            max_idx  <= '0;
            state    <= L_FIND;
          end
        end
        L_FIND: begin
          if (pv) begin
            if (vq) begin
              cnt <= cnt + NW'(1);
              if (tag_q == line) begin
                hit_f   <= 1'b1;
                r_hit   <= rank_q;
                hit_idx <= addr_q;
              end
            end else if (!got_free) begin
              got_free <= 1'b1;
              free_idx <= addr_q;
            end
            // Ranks of free entries only matter when there are none.
            if (rank_q >= max_r) begin
              max_r   <= rank_q;
              max_idx <= addr_q;
            end
          end
          if (end_scan) begin
            idx <= '0;
            if (hit_f) begin
              age_r <= r_hit;
              vic   <= hit_idx;
            end else if (got_free) begin
              age_r <= cnt[RW-1:0];
              vic   <= free_idx;
            end else begin
              age_r <= max_r;
              vic   <= max_idx;
            end
            state <= L_AGE;
          end
        end
        L_AGE: begin
          if (end_scan) begin
            state <= L_FILL;
          end
        end
        L_FILL: begin
          done_q <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.busy = (state == L_CLR);
  assign stat.done = done_q;
  assign stat.hit  = hit_f;

endmodule

// File: rtl/cache_miss_3c_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_miss_3c_classifier
// Sorts data-cache miss addresses into compulsory, capacity and conflict.
// ----------------------------------------------------------------------------
// An item on the input channel is one miss address; each gives exactly one
// result item with its kind, an out-of-range flag and four saturating counts.
// Both channels move an item when valid is high and stall is low. The block
// holds one item at a time: input stall stays high from acceptance until the
// result has been placed in the output register.
// An in-range item reads and checks the seen map, then passes the fully
// associative shadow cache and then the set-associative one: each sweeps its
// memory twice over its effective capacity or ways, once to look up and once
// to age ranks, then fills the line; the counters are updated before the
// result is loaded. The next item can be taken in the cycle after the result
// is loaded. An out-of-range item skips the seen map, caches and counters.
// After reset the seen map is cleared one entry a cycle and both shadow
// memories are cleared over their depth in parallel; no item is accepted
// until all of that is over. The user is to write configuration only while
// no item is in flight; the block does not enforce it. Each write empties
// both shadow caches by the same clearing pass, and the input stalls until
// it is done. A result waits in T_OUT while the output register is stalled.
// ----------------------------------------------------------------------------
module cache_miss_3c_classifier #(
  parameter int SEEN_LINE_BITS = 20,
  parameter int FA_MAX_LINES   = 512,
  parameter int MAX_SETS       = 64,
  parameter int MAX_WAYS       = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] miss_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  miss_kind,
  output logic        out_of_range,
  output logic [39:0] total_count,
  output logic [39:0] compulsory_count,
  output logic [39:0] capacity_count,
  output logic [39:0] conflict_count
);

  localparam int SB         = SEEN_LINE_BITS;
  localparam int FA_IW      = (FA_MAX_LINES > 1) ? $clog2(FA_MAX_LINES) : 1;
  localparam int FA_NW      = $clog2(FA_MAX_LINES + 1);
  localparam int SET_BITS   = $clog2(MAX_SETS + 1) - 1;
  localparam int SETW       = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int SA_ENTRIES = (1 << SET_BITS) * MAX_WAYS;
  localparam int SA_IW      = (SA_ENTRIES > 1) ? $clog2(SA_ENTRIES) : 1;
  localparam int SA_NW      = $clog2(MAX_WAYS + 1);

  typedef enum logic [7:0] {
    T_CLR  = 8'b0000_0001,
    T_IDLE = 8'b0000_0010,
    T_SRD  = 8'b0000_0100,
    T_SCHK = 8'b0000_1000,
    T_FA   = 8'b0001_0000,
    T_SA   = 8'b0010_0000,
    T_CNT  = 8'b0100_0000,
    T_OUT  = 8'b1000_0000
  } tstate_t;

  tstate_t state;

  logic [3:0] line_shift;
  logic [2:0] set_index_bits;
  logic [3:0] ways_in_use;
  logic [9:0] full_assoc_lines;

  logic [31:0] line_r;
  logic oor_r, comp_r;
  logic [1:0] kind_r;
  logic [SB-1:0] clr_idx;
  logic seen_mem [2**SB];
  logic seen_q;
  logic [c3c_pkg::CNT_W-1:0] cnt_total, cnt_comp, cnt_cap, cnt_conf;

  logic [31:0] line_in;
  logic accept, fa_start, sa_start, out_load;
  logic [FA_NW-1:0] fa_n;
  logic [SA_NW-1:0] sa_n;
  logic [3:0] eff_bits;
  logic [SETW-1:0] set_idx;
  logic [SA_IW-1:0] sa_base;
  c3c_pkg::lru_stat_t fa_stat, sa_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift       <= 4'd6;
      set_index_bits   <= 3'd6;
      ways_in_use      <= 4'd8;
      full_assoc_lines <= 10'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c3c_pkg::REG_LINE_SHIFT: line_shift       <= cfg_data[3:0];
        c3c_pkg::REG_SET_BITS:   set_index_bits   <= cfg_data[2:0];
        c3c_pkg::REG_WAYS:       ways_in_use      <= cfg_data[3:0];
        c3c_pkg::REG_FA_LINES:   full_assoc_lines <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (full_assoc_lines == 10'd0) begin
      fa_n = FA_NW'(1);
    end else if (int'(full_assoc_lines) > FA_MAX_LINES) begin
      fa_n = FA_NW'(FA_MAX_LINES);
    end else begin
      fa_n = FA_NW'(full_assoc_lines);
    end
    if (ways_in_use == 4'd0) begin
      sa_n = SA_NW'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      sa_n = SA_NW'(MAX_WAYS);
    end else begin
      sa_n = SA_NW'(ways_in_use);
    end
    eff_bits = (int'(set_index_bits) > SET_BITS) ? 4'(SET_BITS) : {1'b0, set_index_bits};
  end

  assign set_idx = line_r[SETW-1:0] & ~({SETW{1'b1}} << eff_bits);
  assign sa_base = SA_IW'(set_idx * MAX_WAYS);

  assign line_in  = miss_address >> line_shift;
  assign in_stall = (state != T_IDLE) || cfg_we || fa_stat.busy || sa_stat.busy;
  assign accept   = in_valid && !in_stall;
  assign fa_start = (state == T_SCHK);
  assign sa_start = (state == T_FA) && fa_stat.done;
  assign out_load = (state == T_OUT) && (!out_valid || !out_stall);

  // Seen map: one bit per line number, registered read.
  always_ff @(posedge clk) begin
    if (state == T_CLR) begin
      seen_mem[clr_idx] <= 1'b0;
    end else if (state == T_SCHK && !seen_q) begin
      seen_mem[line_r[SB-1:0]] <= 1'b1;
    end
    if (state == T_SRD) begin
      seen_q <= seen_mem[line_r[SB-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLR;
      clr_idx   <= '0;
      cnt_total <= '0;
      cnt_comp  <= '0;
      cnt_cap   <= '0;
      cnt_conf  <= '0;
    end else begin
      unique case (state)
        T_CLR: begin
          clr_idx <= clr_idx + SB'(1);
          if (&clr_idx) begin
            state <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept) begin
            line_r <= line_in;
            oor_r  <= (line_in >> SB) != 32'd0;
            kind_r <= c3c_pkg::KIND_COMPULSORY;
            state  <= ((line_in >> SB) != 32'd0) ? T_OUT : T_SRD;
          end
        end
        T_SRD: state <= T_SCHK;
        T_SCHK: begin
          comp_r <= !seen_q;
          state  <= T_FA;
        end
        T_FA: begin
          if (fa_stat.done) begin
            if (!comp_r) begin
              kind_r <= fa_stat.hit ? c3c_pkg::KIND_CONFLICT : c3c_pkg::KIND_CAPACITY;
            end
            state <= T_SA;
          end
        end
        T_SA: begin
          if (sa_stat.done) begin
            state <= T_CNT;
          end
        end
        T_CNT: begin
          if (cnt_total != c3c_pkg::CNT_MAX) begin
            cnt_total <= cnt_total + 40'd1;
          end
          case (kind_r)
            c3c_pkg::KIND_COMPULSORY:
              if (cnt_comp != c3c_pkg::CNT_MAX) cnt_comp <= cnt_comp + 40'd1;
            c3c_pkg::KIND_CAPACITY:
              if (cnt_cap != c3c_pkg::CNT_MAX) cnt_cap <= cnt_cap + 40'd1;
            default:
              if (cnt_conf != c3c_pkg::CNT_MAX) cnt_conf <= cnt_conf + 40'd1;
          endcase
          state <= T_OUT;
        end
        T_OUT: begin
          if (out_load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      miss_kind        <= kind_r;
      out_of_range     <= oor_r;
      total_count      <= cnt_total;
      compulsory_count <= cnt_comp;
      capacity_count   <= cnt_cap;
      conflict_count   <= cnt_conf;
    end
  end

  c3c_lru #(
    .ENTRIES(FA_MAX_LINES),
    .SPAN   (FA_MAX_LINES)
  ) u_fa (
    .clk  (clk),
    .rst  (rst),
    .clear(cfg_we),
    .start(fa_start),
    .line (line_r),
    .base (FA_IW'(0)),
    .n    (fa_n),
    .stat (fa_stat)
  );

  c3c_lru #(
    .ENTRIES(SA_ENTRIES),
    .SPAN   (MAX_WAYS)
  ) u_sa (
    .clk  (clk),
    .rst  (rst),
    .clear(cfg_we),
    .start(sa_start),
    .line (line_r),
    .base (sa_base),
    .n    (sa_n),
    .stat (sa_stat)
  );

endmodule

// File: sim/cache_miss_3c_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_miss_3c_classifier_test
// Self-checking testbench for the three-C miss classifier.
// ----------------------------------------------------------------------------
// Miss addresses are sent through the valid/stall input channel while the
// result channel is stalled at random. A behavioral model of the seen map, the
// two LRU shadow caches and the counters predicts every result item, and each
// received item is compared field by field. A directed pass covers the range
// edges, every miss kind and the out-of-bounds register values; random phases
// then reuse small pools of lines under many register settings.
// ----------------------------------------------------------------------------
module cache_miss_3c_classifier_test;

  localparam int SEEN_BITS = 20;
  localparam int FA_LINES_MAX = 512;
  localparam int SETS_MAX = 64;
  localparam int WAYS_MAX = 8;

  typedef struct {
    logic [1:0]  kind;
    logic        oor;
    logic [39:0] cnt [4];
  } miss_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = c3c_pkg::REG_LINE_SHIFT;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] miss_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  miss_kind;
  logic        out_of_range;
  logic [39:0] total_count;
  logic [39:0] compulsory_count;
  logic [39:0] capacity_count;
  logic [39:0] conflict_count;

  cache_miss_3c_classifier dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .miss_address(miss_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .miss_kind(miss_kind), .out_of_range(out_of_range),
    .total_count(total_count), .compulsory_count(compulsory_count),
    .capacity_count(capacity_count), .conflict_count(conflict_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state. Entries 0..511 hold the fully associative shadow, 512 on
  // the set-associative one with eight ways reserved per set.
  bit          seen_tab [0:(1<<SEEN_BITS)-1];
  bit   [31:0] shadow_tag [0:1023];
  bit          shadow_valid [0:1023];
  int          shadow_rank [0:1023];
  logic [39:0] class_cnt [4];
  int          m_shift, m_set_bits, m_ways, m_fa_lines;

  miss_result_t result_q [$];
  int          fail_cnt = 0;
  int          phase_cnt = 0;
  bit          rx_quiet = 1'b0;
  int          rx_hold = 0;

  function automatic void clear_shadows();
    for (int i = 0; i < 1024; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
  endfunction

  function automatic bit lru_touch(int base, int n, bit [31:0] line);
    int cnt, victim, hit, r;
    bit got_free;
    cnt = 0; victim = 0; hit = -1; got_free = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (shadow_valid[base+i]) begin
        cnt++;
        if (shadow_tag[base+i] == line) hit = i;
      end else if (!got_free) begin
        got_free = 1'b1;
        victim = i;
      end
    end
    if (hit >= 0) begin
      r = shadow_rank[base+hit];
      for (int i = 0; i < n; i++)
        if (shadow_valid[base+i] && shadow_rank[base+i] < r) shadow_rank[base+i]++;
      shadow_rank[base+hit] = 0;
      return 1'b1;
    end
    if (got_free) begin
      r = cnt;
    end else begin
      r = 0;
      for (int i = 0; i < n; i++)
        if (shadow_rank[base+i] >= r) begin
          r = shadow_rank[base+i];
          victim = i;
        end
    end
    for (int i = 0; i < n; i++)
      if (i != victim && shadow_valid[base+i] && shadow_rank[base+i] < r)
        shadow_rank[base+i]++;
    shadow_tag[base+victim] = line;
    shadow_valid[base+victim] = 1'b1;
    shadow_rank[base+victim] = 0;
    return 1'b0;
  endfunction

  function automatic bit fa_touch(bit [31:0] line);
    int cap;
    cap = m_fa_lines;
    if (cap == 0) cap = 1;
    if (cap > FA_LINES_MAX) cap = FA_LINES_MAX;
    return lru_touch(0, cap, line);
  endfunction

  function automatic bit sa_touch(bit [31:0] line);
    int ways, sets;
    ways = m_ways;
    sets = 1 << m_set_bits;
    if (ways == 0) ways = 1;
    if (ways > WAYS_MAX) ways = WAYS_MAX;
    while (sets > SETS_MAX) sets = sets >> 1;
    return lru_touch(512 + (line & (sets - 1)) * WAYS_MAX, ways, line);
  endfunction

  function automatic void bump(int k);
    if (class_cnt[k] != c3c_pkg::CNT_MAX) class_cnt[k]++;
  endfunction

  function automatic miss_result_t classify_miss(bit [31:0] addr);
    miss_result_t res;
    bit [31:0] line;
    bit dummy;
    line = addr >> m_shift;
    res.kind = c3c_pkg::KIND_COMPULSORY;
    res.oor = 1'b0;
    if (line >= (32'd1 << SEEN_BITS)) begin
      res.oor = 1'b1;
    end else begin
      bump(0);
      if (!seen_tab[line]) begin
        seen_tab[line] = 1'b1;
        bump(1);
        dummy = fa_touch(line);
        dummy = sa_touch(line);
      end else if (!fa_touch(line)) begin
        bump(2);
        res.kind = c3c_pkg::KIND_CAPACITY;
        dummy = sa_touch(line);
      end else begin
        dummy = sa_touch(line);
        bump(3);
        res.kind = c3c_pkg::KIND_CONFLICT;
      end
    end
    res.cnt = class_cnt;
    return res;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    miss_result_t want;
    if (out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        if (miss_kind !== want.kind) begin
          $error("miss_kind: expected %0d, got %0d", want.kind, miss_kind);
          fail_cnt++;
        end
        if (out_of_range !== want.oor) begin
          $error("out_of_range: expected %0d, got %0d", want.oor, out_of_range);
          fail_cnt++;
        end
        if (total_count !== want.cnt[0]) begin
          $error("total_count: expected %0d, got %0d", want.cnt[0], total_count);
          fail_cnt++;
        end
        if (compulsory_count !== want.cnt[1]) begin
          $error("compulsory_count: expected %0d, got %0d", want.cnt[1], compulsory_count);
          fail_cnt++;
        end
        if (capacity_count !== want.cnt[2]) begin
          $error("capacity_count: expected %0d, got %0d", want.cnt[2], capacity_count);
          fail_cnt++;
        end
        if (conflict_count !== want.cnt[3]) begin
          $error("conflict_count: expected %0d, got %0d", want.cnt[3], conflict_count);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(negedge clk) begin
    int p;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      p = $urandom_range(99);
      if (p < 60) begin
        out_stall <= 1'b0;
      end else if (p < 95) begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(3);
      end else begin
        out_stall <= 1'b1;
        rx_hold <= $urandom_range(60, 20);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(4, 1);
    return $urandom_range(120, 20);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_miss(bit [31:0] addr, bit no_gap = 1'b0);
    int gap;
    miss_address = addr;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    result_q.push_back(classify_miss(addr));
    @(negedge clk);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[9:0];
    @(posedge clk);
    case (idx)
      c3c_pkg::REG_LINE_SHIFT: m_shift = val & 15;
      c3c_pkg::REG_SET_BITS:   m_set_bits = val & 7;
      c3c_pkg::REG_WAYS:       m_ways = val & 15;
      default:                 m_fa_lines = val & 1023;
    endcase
    clear_shadows();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed();
    rx_quiet = 1'b1;
    // Reset settings: 64-byte lines, so line 2^20 starts at 0x4000000.
    send_miss(32'h0000_0000, 1'b1);
    send_miss(32'h0000_003F, 1'b1);
    send_miss(32'h03FF_FFFF);
    send_miss(32'h0400_0000);
    send_miss(32'hFFFF_FFFF);
    // A one-line fully associative shadow evicts on every new line.
    write_reg(c3c_pkg::REG_FA_LINES, 1);
    send_miss(32'h0000_1000);
    send_miss(32'h0000_2000);
    send_miss(32'h0000_1000);
    send_miss(32'h0000_1000);
    // Zero capacity and zero ways behave as one.
    write_reg(c3c_pkg::REG_FA_LINES, 0);
    write_reg(c3c_pkg::REG_WAYS, 0);
    send_miss(32'h0000_2000);
    send_miss(32'h0000_1000);
    // Oversized values are clamped; 128 sets fold to 64.
    write_reg(c3c_pkg::REG_FA_LINES, 1023);
    write_reg(c3c_pkg::REG_WAYS, 15);
    write_reg(c3c_pkg::REG_SET_BITS, 7);
    send_miss(32'h0000_2000);
    send_miss(32'h0000_2000);
    // Byte-granular lines and the largest shift.
    write_reg(c3c_pkg::REG_LINE_SHIFT, 0);
    send_miss(32'h000F_FFFF);
    send_miss(32'h0010_0000);
    write_reg(c3c_pkg::REG_LINE_SHIFT, 15);
    send_miss(32'hFFFF_FFFF);
    send_miss(32'h0000_7FFF);
    write_reg(c3c_pkg::REG_LINE_SHIFT, 12);
    send_miss(32'hFFFF_F000);
    send_miss(32'h0000_0FFF);
    drain();
    rx_quiet = 1'b0;
  endtask

  // One random phase: new settings, then misses mostly from a small line pool.
  task automatic run_phase(int shift, int set_bits, int ways, int fa_lines, int n_items);
    int pool_n, base, stride, p;
    bit [31:0] line, addr, line_mask;
    write_reg(c3c_pkg::REG_LINE_SHIFT, shift);
    write_reg(c3c_pkg::REG_SET_BITS, set_bits);
    write_reg(c3c_pkg::REG_WAYS, ways);
    write_reg(c3c_pkg::REG_FA_LINES, fa_lines);
    rx_quiet = ($urandom_range(3) == 0);
    phase_cnt++;
    pool_n = $urandom_range((fa_lines > 40 ? 40 : fa_lines) + 6, 2);
    base = $urandom_range((1 << SEEN_BITS) - 8192);
    // A stride of a multiple of the set count piles lines into one set.
    stride = ($urandom_range(1)) ? (1 << set_bits) * $urandom_range(3, 1) : 1;
    line_mask = (shift > 12) ? ((32'd1 << (32 - shift)) - 1) : 32'hFFFF_FFFF;
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(99);
      if (p < 85) begin
        line = (base + stride * $urandom_range(pool_n - 1)) & line_mask;
        addr = (line << shift) | ($urandom() & ((32'd1 << shift) - 1));
      end else if (p < 93) begin
        addr = $urandom();
      end else begin
        line = (1 << SEEN_BITS) - 2 + $urandom_range(3);
        addr = (line << shift) | ($urandom() & ((32'd1 << shift) - 1));
      end
      send_miss(addr);
      // Let every outstanding result arrive once in a while.
      if ($urandom_range(40) == 0) drain();
    end
  endtask

  task automatic test_random();
    // Extremes first, including the full 512-line shadow at a low count.
    run_phase(6, 6, 8, 512, 30);
    run_phase(0, 0, 1, 1, 100);
    run_phase(15, 7, 15, 2, 80);
    run_phase(12, 3, 4, 16, 100);
    run_phase(4, 1, 2, 8, 100);
    for (int k = 0; k < 9; k++)
      run_phase($urandom_range(15), $urandom_range(7), $urandom_range(15),
                $urandom_range(48), 95);
    drain();
  endtask

  initial begin
    m_shift = 6;
    m_set_bits = 6;
    m_ways = 8;
    m_fa_lines = 512;
    clear_shadows();
    for (int k = 0; k < 4; k++) class_cnt[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    repeat (100) @(posedge clk);
    $display("Ran the directed pass and %0d register settings; %0d compulsory,", phase_cnt,
             class_cnt[1]);
    $display("%0d capacity and %0d conflict misses were classified.", class_cnt[2],
             class_cnt[3]);
    if (fail_cnt == 0) begin
      $display("** cache_miss_3c_classifier: PASSED **");
    end else begin
      $display("** cache_miss_3c_classifier: FAILED **");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("** cache_miss_3c_classifier: FAILED **");
    $finish;
  end

endmodule

// File: cache_miss_3c_classifier.f
rtl/c3c_pkg.sv
rtl/c3c_lru.sv
rtl/cache_miss_3c_classifier.sv
sim/cache_miss_3c_classifier_test.sv
